### hdl/gmaze_pkg.sv
`timescale 1ns / 1ps
// gmaze_pkg: shared types and constants of the grid maze route finder
// no dependencies; imported by the heap, the square root unit and the top level

package gmaze_pkg;

  localparam int X_W        = 6;
  localparam int Y_W        = 5;
  localparam int LEN_W      = 12;
  localparam int G_W        = 12;
  localparam int SEQ_W      = 11;
  localparam int SQ_W       = 13;
  localparam int RT_W       = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_SEARCH = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_Y = 2'd1;

  // way back to the parent cell
  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_LEFT  = 2'd1;
  localparam logic [1:0] DIR_DOWN  = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

  typedef struct packed {
    logic [1:0]     command;
    logic [X_W-1:0] cell_x;
    logic [Y_W-1:0] cell_y;
    logic           open_right;
    logic           open_down;
    logic [X_W-1:0] start_x;
    logic [Y_W-1:0] start_y;
  } cmd_t;

  typedef struct packed {
    logic             found;
    logic [LEN_W-1:0] route_length;
    logic [X_W-1:0]   point_x;
    logic [Y_W-1:0]   point_y;
    logic             last_point;
  } res_t;

  // total and seq first: {total, seq} is the ordering key
  typedef struct packed {
    logic [G_W-1:0]   total;
    logic [SEQ_W-1:0] seq;
    logic [X_W-1:0]   x;
    logic [Y_W-1:0]   y;
    logic [G_W-1:0]   g;
  } heap_entry_t;

  typedef struct packed {
    logic clr;
    logic push;
    logic pop;
  } heap_req_t;

  typedef struct packed {
    logic done;
    logic empty;
  } heap_stat_t;

endpackage

### hdl/gmaze_isqrt.sv
`timescale 1ns / 1ps
// gmaze_isqrt: floor(sqrt(dx*dx + dy*dy)), one result bit per cycle
// depends on gmaze_pkg

module gmaze_isqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [gmaze_pkg::X_W-1:0]  dx_i,
  input  logic [gmaze_pkg::Y_W-1:0]  dy_i,
  output logic                       done_o,
  output logic [gmaze_pkg::RT_W-1:0] root_o
);
  import gmaze_pkg::*;

  localparam int BIT_W = $clog2(RT_W);
  localparam int TSQ_W = 2 * RT_W;

  logic             busy_q;
  logic             done_q;
  logic [SQ_W-1:0]  sum_q;
  logic [RT_W-1:0]  root_q;
  logic [BIT_W-1:0] bit_q;
  logic [RT_W-1:0]  trial;
  logic [TSQ_W-1:0] trial_sq;

  assign trial    = root_q | (RT_W'(1) << bit_q);
  assign trial_sq = TSQ_W'(trial) * TSQ_W'(trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      sum_q  <= '0;
      root_q <= '0;
      bit_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        sum_q  <= SQ_W'(dx_i) * SQ_W'(dx_i) + SQ_W'(dy_i) * SQ_W'(dy_i);
        root_q <= '0;
        bit_q  <= BIT_W'(RT_W - 1);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        if (trial_sq <= TSQ_W'(sum_q)) begin
          root_q <= trial;
        end
        if (bit_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          bit_q <= bit_q - 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

### hdl/gmaze_heap.sv
`timescale 1ns / 1ps
// gmaze_heap: binary min-heap of open entries in one synchronous memory
// depends on gmaze_pkg

module gmaze_heap #(
  parameter int DEPTH = 2048
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  gmaze_pkg::heap_req_t   req_i,
  input  gmaze_pkg::heap_entry_t entry_i,
  output gmaze_pkg::heap_stat_t  stat_o,
  output gmaze_pkg::heap_entry_t top_o
);
  import gmaze_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [3:0] {
    H_IDLE, H_UP, H_UPCMP, H_RD0, H_LAST, H_C1, H_C2, H_C3, H_DEC
  } hstate_e;

  heap_entry_t heap_mem [DEPTH];
  heap_entry_t rdata_q;

  hstate_e     state_q;
  logic [AW:0] cnt_q;
  logic [AW-1:0] idx_q;
  logic [AW-1:0] cidx_q;
  heap_entry_t ent_q;
  heap_entry_t cand_q;
  heap_entry_t top_q;
  logic        done_q;

  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic          wr_en;
  heap_entry_t   wr_data;
  logic [AW:0]   child;
  logic [AW:0]   child_n;
  logic [AW-1:0] parent;

  function automatic logic less(input heap_entry_t a, input heap_entry_t b);
    return {a.total, a.seq} < {b.total, b.seq};
  endfunction

  assign child   = {idx_q, 1'b1};
  assign child_n = child + (AW+1)'(1);
  assign parent  = (idx_q - AW'(1)) >> 1;

  always_comb begin
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = idx_q;
    wr_data = ent_q;
    case (state_q)
      H_UP: begin
        if (idx_q == '0) begin
          wr_en = 1'b1;
        end else begin
          rd_addr = parent;
        end
      end
      H_UPCMP: begin
        wr_en   = 1'b1;
        wr_data = less(ent_q, rdata_q) ? rdata_q : ent_q;
      end
      H_RD0: rd_addr = cnt_q[AW-1:0];
      H_C1: begin
        if (child < cnt_q) begin
          rd_addr = child[AW-1:0];
        end else begin
          wr_en = 1'b1;
        end
      end
      H_C2: rd_addr = child_n[AW-1:0];
      H_DEC: begin
        wr_en   = 1'b1;
        wr_data = less(cand_q, ent_q) ? cand_q : ent_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      heap_mem[wr_addr] <= wr_data;
    end
    rdata_q <= heap_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= H_IDLE;
      cnt_q   <= '0;
      idx_q   <= '0;
      cidx_q  <= '0;
      ent_q   <= '0;
      cand_q  <= '0;
      top_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        H_IDLE: begin
          if (req_i.clr) begin
            cnt_q <= '0;
          end else if (req_i.push) begin
            if (cnt_q == (AW+1)'(DEPTH)) begin
              done_q <= 1'b1;
            end else begin
              ent_q   <= entry_i;
              idx_q   <= cnt_q[AW-1:0];
              cnt_q   <= cnt_q + 1'b1;
              state_q <= H_UP;
            end
          end else if (req_i.pop) begin
            cnt_q   <= cnt_q - 1'b1;
            state_q <= H_RD0;
          end
        end
        H_UP: begin
          if (idx_q == '0) begin
            done_q  <= 1'b1;
            state_q <= H_IDLE;
          end else begin
            state_q <= H_UPCMP;
          end
        end
        H_UPCMP: begin
          if (less(ent_q, rdata_q)) begin
            idx_q   <= parent;
            state_q <= H_UP;
          end else begin
            done_q  <= 1'b1;
            state_q <= H_IDLE;
          end
        end
        H_RD0: begin
          top_q <= rdata_q;
          if (cnt_q == '0) begin
            done_q  <= 1'b1;
            state_q <= H_IDLE;
          end else begin
            state_q <= H_LAST;
          end
        end
        H_LAST: begin
          ent_q   <= rdata_q;
          idx_q   <= '0;
          state_q <= H_C1;
        end
        H_C1: begin
          if (child < cnt_q) begin
            state_q <= H_C2;
          end else begin
            done_q  <= 1'b1;
            state_q <= H_IDLE;
          end
        end
        H_C2: begin
          cand_q <= rdata_q;
          cidx_q <= child[AW-1:0];
          state_q <= (child_n < cnt_q) ? H_C3 : H_DEC;
        end
        H_C3: begin
          if (less(rdata_q, cand_q)) begin
            cand_q <= rdata_q;
            cidx_q <= child_n[AW-1:0];
          end
          state_q <= H_DEC;
        end
        H_DEC: begin
          if (less(cand_q, ent_q)) begin
            idx_q   <= cidx_q;
            state_q <= H_C1;
          end else begin
            done_q  <= 1'b1;
            state_q <= H_IDLE;
          end
        end
        default: state_q <= H_IDLE;
      endcase
    end
  end

  assign stat_o.done  = done_q;
  assign stat_o.empty = (cnt_q == '0);
  assign top_o        = top_q;

endmodule

### hdl/grid_maze_astar_search_top.sv
`timescale 1ns / 1ps
// grid_maze_astar_search_top: A* route finder over a walled grid, wall and node memories
// depends on gmaze_pkg, gmaze_heap, gmaze_isqrt
//
// channel   | handshake                  | word
// ----------+----------------------------+---------------------------------
// command   | start_i / busy_o           | cmd_i (gmaze_pkg::cmd_t)
// result    | done_o, one-cycle strobe   | res_o (gmaze_pkg::res_t)
// config    | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// a load or a read is answered from idle; a read that moves the route on then waits in S_RWAIT
// (the node memory fetches the parent direction of the new route cell)
// a search first clears the visited bits, one cell a cycle, then per popped cell:
// heap pop (sifting down level by level), up to four neighbour checks (read, then
// check), each discovery a square root and a heap push with sift-up; the route is then
// counted back point by point
// async active-low reset; one result per command, which the receiver cannot stall

module grid_maze_astar_search_top #(
  parameter int GRID_W = 64,
  parameter int GRID_H = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  gmaze_pkg::cmd_t                  cmd_i,
  output logic                             done_o,
  output gmaze_pkg::res_t                  res_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [gmaze_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [gmaze_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import gmaze_pkg::*;

  localparam int CELLS = GRID_W * GRID_H;
  localparam int AW    = $clog2(CELLS);

  // neighbour order: up, down, left, right
  localparam logic [1:0] NB_UP    = 2'd0;
  localparam logic [1:0] NB_DOWN  = 2'd1;
  localparam logic [1:0] NB_LEFT  = 2'd2;
  localparam logic [1:0] NB_RIGHT = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE, S_RWAIT, S_CLEAR, S_SEED, S_HWAIT, S_PWAIT,
    S_POP, S_POPWAIT, S_NRD, S_NCHK, S_LCHK, S_LSTEP
  } state_e;

  typedef struct packed {
    logic [X_W-1:0] x;
    logic [Y_W-1:0] y;
  } xy_t;

  function automatic logic [AW-1:0] cell_at(input logic [X_W-1:0] x,
                                            input logic [Y_W-1:0] y);
    return AW'(y) * AW'(GRID_W) + AW'(x);
  endfunction

  function automatic xy_t step_back(input logic [X_W-1:0] x, input logic [Y_W-1:0] y,
                                    input logic [1:0] dir);
    xy_t r;
    r.x = x;
    r.y = y;
    case (dir)
      DIR_UP:   r.y = y - 1'b1;
      DIR_LEFT: r.x = x - 1'b1;
      DIR_DOWN: r.y = y + 1'b1;
      default:  r.x = x + 1'b1;
    endcase
    return r;
  endfunction

  // memories: walls {open_down, open_right}; node {visited, parent direction}
  logic [1:0] wall_mem [CELLS];
  logic [2:0] node_mem [CELLS];
  logic [1:0] wall_rdata_q;
  logic [2:0] node_rdata_q;

  logic [AW-1:0] wall_raddr, wall_waddr, node_raddr, node_waddr;
  logic          wall_we, node_we;
  logic [1:0]    wall_wdata;
  logic [2:0]    node_wdata;

  // control and route state
  state_e           state_q;
  logic [X_W-1:0]   tx_q;
  logic [Y_W-1:0]   ty_q;
  logic [X_W-1:0]   start_x_q, cur_x_q, nb_x_q, route_x_q;
  logic [Y_W-1:0]   start_y_q, cur_y_q, nb_y_q, route_y_q;
  logic [G_W-1:0]   cur_g_q, nb_g_q;
  logic [1:0]       nb_back_q;
  logic             nb_wsel_q;
  logic [1:0]       k_q;
  logic             seed_q;
  logic [AW-1:0]    clr_idx_q;
  logic [SEQ_W-1:0] seq_q;
  logic             route_valid_q;
  logic [LEN_W-1:0] route_len_q, route_cursor_q;
  logic             done_q;
  res_t             res_q;

  // neighbour of the popped cell under test
  logic           nb_ok, nb_wsel;
  logic [X_W-1:0] nb_nx, nb_wx;
  logic [Y_W-1:0] nb_ny, nb_wy;
  logic [1:0]     nb_bk;
  logic           nb_take;

  logic        accept, load_in, start_in, tgt_in;
  logic        rd_live, rd_end;
  xy_t         route_prev, walk_prev;
  heap_req_t   heap_req;
  heap_stat_t  heap_stat;
  heap_entry_t heap_in, heap_top;
  logic        sq_start, sq_done;
  logic [RT_W-1:0] sq_root;
  logic [X_W-1:0]  sq_x, sq_dx;
  logic [Y_W-1:0]  sq_y, sq_dy;

  assign accept   = start_i && (state_q == S_IDLE);
  assign load_in  = (int'(cmd_i.cell_x) < GRID_W) && (int'(cmd_i.cell_y) < GRID_H);
  assign start_in = (int'(cmd_i.start_x) < GRID_W) && (int'(cmd_i.start_y) < GRID_H);
  assign tgt_in   = (int'(tx_q) < GRID_W) && (int'(ty_q) < GRID_H);

  always_comb begin
    nb_ok   = 1'b0;
    nb_nx   = cur_x_q;
    nb_ny   = cur_y_q;
    nb_wx   = cur_x_q;
    nb_wy   = cur_y_q;
    nb_wsel = 1'b0;
    nb_bk   = DIR_UP;
    case (k_q)
      NB_UP: begin
        nb_ok   = (cur_y_q != '0);
        nb_ny   = cur_y_q - 1'b1;
        nb_wy   = cur_y_q - 1'b1;
        nb_wsel = 1'b1;
        nb_bk   = DIR_DOWN;
      end
      NB_DOWN: begin
        nb_ok   = (int'(cur_y_q) + 1 < GRID_H);
        nb_ny   = cur_y_q + 1'b1;
        nb_wsel = 1'b1;
        nb_bk   = DIR_UP;
      end
      NB_LEFT: begin
        nb_ok = (cur_x_q != '0);
        nb_nx = cur_x_q - 1'b1;
        nb_wx = cur_x_q - 1'b1;
        nb_bk = DIR_RIGHT;
      end
      NB_RIGHT: begin
        nb_ok = (int'(cur_x_q) + 1 < GRID_W);
        nb_nx = cur_x_q + 1'b1;
        nb_bk = DIR_LEFT;
      end
      default: ;
    endcase
  end

  // passage open and cell not yet discovered
  assign nb_take = (nb_wsel_q ? wall_rdata_q[1] : wall_rdata_q[0]) && !node_rdata_q[2];

  // memory ports
  assign wall_we    = accept && (cmd_i.command == CMD_LOAD) && load_in;
  assign wall_waddr = cell_at(cmd_i.cell_x, cmd_i.cell_y);
  assign wall_wdata = {cmd_i.open_down, cmd_i.open_right};
  assign wall_raddr = cell_at(nb_wx, nb_wy);

  always_comb begin
    case (state_q)
      S_NRD:   node_raddr = cell_at(nb_nx, nb_ny);
      S_LCHK:  node_raddr = cell_at(cur_x_q, cur_y_q);
      default: node_raddr = cell_at(route_x_q, route_y_q);
    endcase
    node_we    = 1'b0;
    node_waddr = cell_at(nb_x_q, nb_y_q);
    node_wdata = {1'b1, nb_back_q};
    case (state_q)
      S_CLEAR: begin
        node_we    = 1'b1;
        node_waddr = clr_idx_q;
        node_wdata = '0;
      end
      S_SEED: begin
        node_we    = 1'b1;
        node_waddr = cell_at(start_x_q, start_y_q);
        node_wdata = {1'b1, DIR_UP};
      end
      S_NCHK: node_we = nb_take;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wall_we) begin
      wall_mem[wall_waddr] <= wall_wdata;
    end
    if (node_we) begin
      node_mem[node_waddr] <= node_wdata;
    end
    wall_rdata_q <= wall_mem[wall_raddr];
    node_rdata_q <= node_mem[node_raddr];
  end

  // heuristic unit
  assign sq_x     = (state_q == S_SEED) ? start_x_q : nb_x_q;
  assign sq_y     = (state_q == S_SEED) ? start_y_q : nb_y_q;
  assign sq_dx    = (sq_x > tx_q) ? sq_x - tx_q : tx_q - sq_x;
  assign sq_dy    = (sq_y > ty_q) ? sq_y - ty_q : ty_q - sq_y;
  assign sq_start = (state_q == S_SEED) || ((state_q == S_NCHK) && nb_take);

  gmaze_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .dx_i    (sq_dx),
    .dy_i    (sq_dy),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  // open list
  assign heap_req.clr  = (state_q == S_CLEAR);
  assign heap_req.push = (state_q == S_HWAIT) && sq_done;
  assign heap_req.pop  = (state_q == S_POP) && !heap_stat.empty;
  assign heap_in.total = G_W'(nb_g_q + G_W'(sq_root));
  assign heap_in.seq   = seq_q;
  assign heap_in.x     = nb_x_q;
  assign heap_in.y     = nb_y_q;
  assign heap_in.g     = nb_g_q;

  gmaze_heap #(
    .DEPTH (CELLS)
  ) u_heap (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (heap_req),
    .entry_i (heap_in),
    .stat_o  (heap_stat),
    .top_o   (heap_top)
  );

  // route read-out; node_rdata_q holds the route cell's parent direction in idle
  assign rd_live    = route_valid_q && (route_cursor_q < route_len_q);
  assign rd_end     = ((route_x_q == start_x_q) && (route_y_q == start_y_q))
                      || (route_cursor_q + 1'b1 >= route_len_q);
  assign route_prev = step_back(route_x_q, route_y_q, node_rdata_q[1:0]);
  assign walk_prev  = step_back(cur_x_q, cur_y_q, node_rdata_q[1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      tx_q           <= X_W'(38);
      ty_q           <= Y_W'(28);
      start_x_q      <= '0;
      start_y_q      <= '0;
      cur_x_q        <= '0;
      cur_y_q        <= '0;
      cur_g_q        <= '0;
      nb_x_q         <= '0;
      nb_y_q         <= '0;
      nb_g_q         <= '0;
      nb_back_q      <= DIR_UP;
      nb_wsel_q      <= 1'b0;
      k_q            <= NB_UP;
      seed_q         <= 1'b0;
      clr_idx_q      <= '0;
      seq_q          <= '0;
      route_valid_q  <= 1'b0;
      route_len_q    <= '0;
      route_cursor_q <= '0;
      route_x_q      <= '0;
      route_y_q      <= '0;
      done_q         <= 1'b0;
      res_q          <= '0;
    end else begin
      done_q <= 1'b0;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_TARGET_X: tx_q <= cfg_data_i[X_W-1:0];
          CFG_TARGET_Y: ty_q <= cfg_data_i[Y_W-1:0];
          default: ;
        endcase
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            res_q.found        <= route_valid_q;
            res_q.route_length <= route_len_q;
            res_q.point_x      <= '0;
            res_q.point_y      <= '0;
            res_q.last_point   <= 1'b0;
            case (cmd_i.command)
              CMD_SEARCH: begin
                start_x_q      <= cmd_i.start_x;
                start_y_q      <= cmd_i.start_y;
                seq_q          <= '0;
                route_valid_q  <= 1'b0;
                route_len_q    <= '0;
                route_cursor_q <= '0;
                route_x_q      <= '0;
                route_y_q      <= '0;
                clr_idx_q      <= '0;
                if (start_in) begin
                  state_q <= S_CLEAR;
                end else begin
                  // start off the grid: fails at once
                  done_q             <= 1'b1;
                  res_q.found        <= 1'b0;
                  res_q.route_length <= '0;
                end
              end
              CMD_READ: begin
                done_q <= 1'b1;
                if (rd_live) begin
                  res_q.point_x  <= route_x_q;
                  res_q.point_y  <= route_y_q;
                  if (rd_end) begin
                    res_q.last_point <= 1'b1;
                    route_cursor_q   <= route_len_q;
                  end else begin
                    route_cursor_q <= route_cursor_q + 1'b1;
                    route_x_q      <= route_prev.x;
                    route_y_q      <= route_prev.y;
                    state_q        <= S_RWAIT;
                  end
                end else begin
                  res_q.last_point <= 1'b1;
                end
              end
              default: done_q <= 1'b1; // load, or a code with no effect
            endcase
          end
        end
        S_RWAIT: state_q <= S_IDLE;
        S_CLEAR: begin
          clr_idx_q <= clr_idx_q + 1'b1;
          if (clr_idx_q == AW'(CELLS - 1)) begin
            state_q <= S_SEED;
          end
        end
        S_SEED: begin
          nb_x_q  <= start_x_q;
          nb_y_q  <= start_y_q;
          nb_g_q  <= '0;
          seed_q  <= 1'b1;
          state_q <= S_HWAIT;
        end
        S_HWAIT: begin
          if (sq_done) begin
            seq_q   <= seq_q + 1'b1;
            state_q <= S_PWAIT;
          end
        end
        S_PWAIT: begin
          if (heap_stat.done) begin
            if (seed_q || (k_q == NB_RIGHT)) begin
              seed_q  <= 1'b0;
              state_q <= S_POP;
            end else begin
              k_q     <= k_q + 1'b1;
              state_q <= S_NRD;
            end
          end
        end
        S_POP: begin
          if (heap_stat.empty) begin
            // open list exhausted: no route
            done_q             <= 1'b1;
            res_q.found        <= 1'b0;
            res_q.route_length <= '0;
            state_q            <= S_RWAIT;
          end else begin
            state_q <= S_POPWAIT;
          end
        end
        S_POPWAIT: begin
          if (heap_stat.done) begin
            cur_x_q <= heap_top.x;
            cur_y_q <= heap_top.y;
            cur_g_q <= heap_top.g;
            if (tgt_in && (heap_top.x == tx_q) && (heap_top.y == ty_q)) begin
              route_x_q   <= heap_top.x;
              route_y_q   <= heap_top.y;
              route_len_q <= LEN_W'(1);
              state_q     <= S_LCHK;
            end else begin
              k_q     <= NB_UP;
              state_q <= S_NRD;
            end
          end
        end
        S_NRD: begin
          nb_x_q    <= nb_nx;
          nb_y_q    <= nb_ny;
          nb_g_q    <= cur_g_q + 1'b1;
          nb_back_q <= nb_bk;
          nb_wsel_q <= nb_wsel;
          if (nb_ok) begin
            state_q <= S_NCHK;
          end else if (k_q == NB_RIGHT) begin
            state_q <= S_POP;
          end else begin
            k_q <= k_q + 1'b1;
          end
        end
        S_NCHK: begin
          if (nb_take) begin
            state_q <= S_HWAIT;
          end else if (k_q == NB_RIGHT) begin
            state_q <= S_POP;
          end else begin
            k_q     <= k_q + 1'b1;
            state_q <= S_NRD;
          end
        end
        S_LCHK: begin
          if (((cur_x_q == start_x_q) && (cur_y_q == start_y_q))
              || (route_len_q >= LEN_W'(CELLS))) begin
            route_valid_q      <= 1'b1;
            done_q             <= 1'b1;
            res_q.found        <= 1'b1;
            res_q.route_length <= route_len_q;
            state_q            <= S_RWAIT;
          end else begin
            state_q <= S_LSTEP;
          end
        end
        S_LSTEP: begin
          cur_x_q     <= walk_prev.x;
          cur_y_q     <= walk_prev.y;
          route_len_q <= route_len_q + 1'b1;
          state_q     <= S_LCHK;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o      = (state_q != S_IDLE);
  assign done_o      = done_q;
  assign res_o       = res_q;
  assign cfg_ready_o = 1'b1;

`ifndef SYNTHESIS
  a_search_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && (cmd_i.command == CMD_SEARCH) && start_in |=> busy_o)
    else $error("search on the grid did not go busy");

  a_cursor_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    route_cursor_q <= route_len_q)
    else $error("route cursor beyond route length");

  a_found_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.found |-> res_o.route_length != '0)
    else $error("route found with zero length");
`endif

endmodule

### tb/tb_grid_maze_astar_search_top.sv
`timescale 1ns / 1ps
// tb_grid_maze_astar_search_top: self-checking bench for the grid maze route finder
// depends on gmaze_pkg and grid_maze_astar_search_top; own A* predictor, driver and monitor

module tb_grid_maze_astar_search_top;
  import gmaze_pkg::*;

  localparam int GRID_W     = 64;
  localparam int GRID_H     = 32;
  localparam int CELLS      = GRID_W * GRID_H;
  localparam int IDLE_LIMIT = 400000;
  // searches stay in the rows from BAND_Y down; the row above is kept closed
  localparam int BAND_Y     = 24;
  localparam logic [1:0] CMD_UNKNOWN = 2'd3;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start_i;
  logic                  busy_o;
  cmd_t                  cmd_i;
  logic                  done_o;
  res_t                  res_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  grid_maze_astar_search_top #(
    .GRID_W(GRID_W),
    .GRID_H(GRID_H)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .cmd_i      (cmd_i),
    .done_o     (done_o),
    .res_o      (res_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // ---------------------------------------------------------------
  // route finder model: own copy of walls, marks, heap and route
  // ---------------------------------------------------------------
  logic [1:0]  wall_bits  [CELLS];  // bit0 open right, bit1 open down
  bit          seen       [CELLS];
  logic [1:0]  way_back   [CELLS];
  int unsigned open_total [CELLS];
  int unsigned open_seq   [CELLS];
  int unsigned open_cell  [CELLS];
  int unsigned open_g     [CELLS];
  int unsigned open_n;
  int unsigned seq_no;
  int unsigned goal_x = 38;
  int unsigned goal_y = 28;
  bit          route_ok;
  int unsigned route_len, route_pos, route_at, route_from;

  res_t        expected_res [$];   // results still owed by the block
  cmd_t        pending_cmd  [$];   // words waiting for the driver
  int          error_count = 0;
  bit          no_gaps;           // stretch with no idling on the command side

  function automatic int unsigned dist_est(int unsigned x, int unsigned y);
    int unsigned dx, dy, s, r;
    dx = (x > goal_x) ? x - goal_x : goal_x - x;
    dy = (y > goal_y) ? y - goal_y : goal_y - y;
    s  = dx * dx + dy * dy;
    r  = 0;
    while ((r + 1) * (r + 1) <= s) r++;
    return r;
  endfunction

  // lower total wins, ties to the earlier insert
  function automatic bit ranks_first(int unsigned t1, int unsigned s1,
                                     int unsigned t2, int unsigned s2);
    if (t1 != t2) return t1 < t2;
    return s1 < s2;
  endfunction

  function automatic void open_push(int unsigned ci, int unsigned g);
    int unsigned i, p, t, s;
    t = g + dist_est(ci % GRID_W, ci / GRID_W);
    s = seq_no++;
    i = open_n++;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (!ranks_first(t, s, open_total[p], open_seq[p])) break;
      open_total[i] = open_total[p];
      open_seq[i]   = open_seq[p];
      open_cell[i]  = open_cell[p];
      open_g[i]     = open_g[p];
      i = p;
    end
    open_total[i] = t;
    open_seq[i]   = s;
    open_cell[i]  = ci;
    open_g[i]     = g;
  endfunction

  function automatic void open_pop(output int unsigned ci, output int unsigned g);
    int unsigned i, c, lt, ls, lc, lg;
    ci = open_cell[0];
    g  = open_g[0];
    open_n--;
    if (open_n == 0) return;
    lt = open_total[open_n];
    ls = open_seq[open_n];
    lc = open_cell[open_n];
    lg = open_g[open_n];
    i  = 0;
    forever begin
      c = 2 * i + 1;
      if (c >= open_n) break;
      if (c + 1 < open_n &&
          ranks_first(open_total[c+1], open_seq[c+1], open_total[c], open_seq[c]))
        c++;
      if (!ranks_first(open_total[c], open_seq[c], lt, ls)) break;
      open_total[i] = open_total[c];
      open_seq[i]   = open_seq[c];
      open_cell[i]  = open_cell[c];
      open_g[i]     = open_g[c];
      i = c;
    end
    open_total[i] = lt;
    open_seq[i]   = ls;
    open_cell[i]  = lc;
    open_g[i]     = lg;
  endfunction

  function automatic void mark_cell(int unsigned ci, int unsigned g, logic [1:0] back);
    if (seen[ci]) return;
    seen[ci]     = 1'b1;
    way_back[ci] = back;
    open_push(ci, g);
  endfunction

  function automatic int unsigned parent_cell(int unsigned ci);
    case (way_back[ci])
      DIR_UP:   return ci - GRID_W;
      DIR_LEFT: return ci - 1;
      DIR_DOWN: return ci + GRID_W;
      default:  return ci + 1;
    endcase
  endfunction

  function automatic void find_route(int unsigned sx, int unsigned sy);
    int unsigned goal, c, g, x, y, n, w;
    foreach (seen[k]) seen[k] = 1'b0;
    open_n     = 0;
    seq_no     = 0;
    route_pos  = 0;
    route_ok   = 1'b0;
    route_len  = 0;
    route_at   = 0;
    route_from = 0;
    if (sx >= GRID_W || sy >= GRID_H) return;
    route_from = sy * GRID_W + sx;
    goal = (goal_x < GRID_W && goal_y < GRID_H) ? goal_y * GRID_W + goal_x : CELLS;
    seen[route_from] = 1'b1;
    open_push(route_from, 0);
    while (open_n > 0) begin
      open_pop(c, g);
      x = c % GRID_W;
      y = c / GRID_W;
      g = g + 1;
      if (c == goal) begin
        n = 1;
        w = c;
        while (w != route_from && n < CELLS) begin
          w = parent_cell(w);
          n++;
        end
        route_ok  = 1'b1;
        route_len = n;
        route_at  = c;
        return;
      end
      if (y > 0 && wall_bits[c-GRID_W][1])      mark_cell(c - GRID_W, g, DIR_DOWN);
      if (y + 1 < GRID_H && wall_bits[c][1])    mark_cell(c + GRID_W, g, DIR_UP);
      if (x > 0 && wall_bits[c-1][0])           mark_cell(c - 1, g, DIR_RIGHT);
      if (x + 1 < GRID_W && wall_bits[c][0])    mark_cell(c + 1, g, DIR_LEFT);
    end
  endfunction

  // works out the result of one accepted command word and queues it
  function automatic void predict_result(cmd_t w);
    res_t r;
    r = '0;
    case (w.command)
      CMD_LOAD: begin
        if (w.cell_x < GRID_W && w.cell_y < GRID_H)
          wall_bits[w.cell_y * GRID_W + w.cell_x] = {w.open_down, w.open_right};
      end
      CMD_SEARCH: find_route(w.start_x, w.start_y);
      CMD_READ: begin
        if (route_ok && route_pos < route_len) begin
          r.point_x = X_W'(route_at % GRID_W);
          r.point_y = Y_W'(route_at / GRID_W);
          route_pos++;
          if (route_at == route_from || route_pos >= route_len) begin
            r.last_point = 1'b1;
            route_pos    = route_len;
          end else begin
            route_at = parent_cell(route_at);
          end
        end else begin
          r.last_point = 1'b1;
        end
      end
      default: ;  // unknown command behaves like a load that changes nothing
    endcase
    r.found        = route_ok;
    r.route_length = route_len[LEN_W-1:0];
    expected_res.insert(expected_res.size(), r);
  endfunction

  // ---------------------------------------------------------------
  // driver: presents queued words, a random gap (none under no_gaps) after each accepted word
  // ---------------------------------------------------------------
  int unsigned gap_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i  <= 1'b0;
      cmd_i    <= '0;
      gap_left <= 0;
    end else if (start_i && !busy_o) begin
      int unsigned wait_n;
      predict_result(cmd_i);
      wait_n = no_gaps ? 0 : $urandom_range(0, 19);
      if (wait_n == 0 && pending_cmd.size() > 0) begin
        cmd_i <= pending_cmd.pop_front();  // start stays high, back-to-back word
      end else begin
        start_i  <= 1'b0;
        gap_left <= wait_n;
      end
    end else if (!start_i) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else if (pending_cmd.size() > 0) begin
        cmd_i   <= pending_cmd.pop_front();
        start_i <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------
  // monitor: checks every strobed result, plus the idle watchdog
  // ---------------------------------------------------------------
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        if (expected_res.size() == 0) begin
          $display("%0t: unexpected result word %h", $time, res_o);
          error_count++;
        end else begin
          res_t e;
          e = expected_res.pop_front();
          if (res_o.found !== e.found) begin
            $display("%0t: found expected %0d got %0d", $time, e.found, res_o.found);
            error_count++;
          end
          if (res_o.route_length !== e.route_length) begin
            $display("%0t: route_length expected %0d got %0d",
                     $time, e.route_length, res_o.route_length);
            error_count++;
          end
          if (res_o.point_x !== e.point_x) begin
            $display("%0t: point_x expected %0d got %0d", $time, e.point_x, res_o.point_x);
            error_count++;
          end
          if (res_o.point_y !== e.point_y) begin
            $display("%0t: point_y expected %0d got %0d", $time, e.point_y, res_o.point_y);
            error_count++;
          end
          if (res_o.last_point !== e.last_point) begin
            $display("%0t: last_point expected %0d got %0d",
                     $time, e.last_point, res_o.last_point);
            error_count++;
          end
        end
      end
      // a search can run long, so only a long spell with no handshake at all trips it
      if (done_o || (start_i && !busy_o) || (cfg_valid_i && cfg_ready_o))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------
  // every field random, so unused fields toggle too
  function automatic cmd_t noise_word(logic [1:0] op);
    cmd_t        w;
    logic [63:0] raw;
    raw       = {$urandom, $urandom};
    w         = raw[$bits(cmd_t)-1:0];
    w.command = op;
    return w;
  endfunction

  function automatic int unsigned near(int unsigned centre, int unsigned span, int unsigned top);
    int v;
    v = int'(centre) + $urandom_range(0, 2 * span) - int'(span);
    if (v < 0) v = 0;
    if (v > int'(top)) v = top;
    return v;
  endfunction

  task automatic queue_load(int unsigned x, int unsigned y, int unsigned open_pct);
    cmd_t w;
    w            = noise_word(CMD_LOAD);
    w.cell_x     = X_W'(x);
    w.cell_y     = Y_W'(y);
    w.open_right = ($urandom_range(0, 99) < open_pct);
    w.open_down  = ($urandom_range(0, 99) < open_pct);
    pending_cmd.insert(pending_cmd.size(), w);
  endtask

  task automatic queue_search(int unsigned x, int unsigned y);
    cmd_t w;
    w         = noise_word(CMD_SEARCH);
    w.start_x = X_W'(x);
    w.start_y = Y_W'(y);
    pending_cmd.insert(pending_cmd.size(), w);
  endtask

  task automatic queue_reads(int unsigned n);
    repeat (n) pending_cmd.insert(pending_cmd.size(), noise_word(CMD_READ));
  endtask

  // block idle: nothing queued, nothing presented, nothing owed
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_cmd.size() > 0 || start_i || expected_res.size() > 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_TARGET_X) goal_x = val;
    else if (idx == CFG_TARGET_Y) goal_y = val & 6'd31;
  endtask

  task automatic set_goal(int unsigned x, int unsigned y);
    wait_idle();
    write_reg(CFG_TARGET_X, CFG_DATA_W'(x));
    write_reg(CFG_TARGET_Y, CFG_DATA_W'(y));
  endtask

  // ---------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------
  initial begin
    int unsigned open_pct, pick, x, y;
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    no_gaps     = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reads before any search, and an unknown command
    queue_reads(2);
    pending_cmd.insert(pending_cmd.size(), noise_word(CMD_UNKNOWN));

    // the band gets walls before any search; the closed row above keeps searches in it
    no_gaps = 1'b1;
    for (int cy = BAND_Y - 1; cy < GRID_H; cy++)
      for (int cx = 0; cx < GRID_W; cx++)
        queue_load(cx, cy, (cy < BAND_Y) ? 0 : 45);
    wait_idle();
    no_gaps = 1'b0;

    // start on the goal at reset setting, then read past the single point
    queue_search(38, 28);
    queue_reads(3);
    // open corridor along the goal row, search from its far end
    for (int cx = 30; cx < 38; cx++) begin
      cmd_t w;
      w            = noise_word(CMD_LOAD);
      w.cell_x     = X_W'(cx);
      w.cell_y     = Y_W'(28);
      w.open_right = 1'b1;
      pending_cmd.insert(pending_cmd.size(), w);
    end
    queue_search(30, 28);
    queue_reads(10);

    // corner goals: edge cells carry open bits pointing off the grid
    set_goal(0, BAND_Y);
    queue_load(0, BAND_Y, 100);
    queue_load(1, BAND_Y, 100);
    queue_search(1, BAND_Y);
    queue_reads(3);
    set_goal(63, 31);
    queue_load(63, 31, 100);
    queue_load(62, 31, 100);
    queue_search(62, 31);
    queue_reads(3);
    wait_idle();

    // random phases, each with its own goal and wall density
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       set_goal(38, 28);
        1:       set_goal(0, 31);
        2:       set_goal(63, 0);
        3:       set_goal(63, 31);
        4:       set_goal(0, BAND_Y);
        default: set_goal($urandom_range(0, 63), $urandom_range(0, 31));
      endcase
      no_gaps  = (phase % 3 == 1);
      open_pct = $urandom_range(30, 75);
      for (int n = 0; n < 40; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
          // most loads land around the goal so searches see them
          if ($urandom_range(0, 9) < 7) begin
            x = near(goal_x, 6, GRID_W - 1);
            y = near(goal_y, 6, GRID_H - 1);
            if (y < BAND_Y) y = $urandom_range(BAND_Y, GRID_H - 1);
          end else begin
            x = $urandom_range(0, GRID_W - 1);
            y = $urandom_range(BAND_Y, GRID_H - 1);
          end
          queue_load(x, y, open_pct);
        end else if (pick < 56) begin
          // well-formed sequence: search then walk the route back
          if ($urandom_range(0, 4) != 0) begin
            x = near(goal_x, 5, GRID_W - 1);
            y = near(goal_y, 5, GRID_H - 1);
            if (y < BAND_Y) y = $urandom_range(BAND_Y, GRID_H - 1);
          end else begin
            x = $urandom_range(0, GRID_W - 1);
            y = $urandom_range(BAND_Y, GRID_H - 1);
          end
          queue_search(x, y);
          queue_reads($urandom_range(0, 25));
        end else if (pick < 60) begin
          pending_cmd.insert(pending_cmd.size(), noise_word(CMD_UNKNOWN));
        end else begin
          queue_reads(1);
        end
      end
    end

    wait_idle();
    repeat (20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### sim.f
hdl/gmaze_pkg.sv
hdl/gmaze_isqrt.sv
hdl/gmaze_heap.sv
hdl/grid_maze_astar_search_top.sv
tb/tb_grid_maze_astar_search_top.sv
